// ===== src/ilid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_pkg: shared types and constants for the indexed list core
// Operation and status codes, fixed field widths, and the command that the
// control logic broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package ilid_pkg;

    // Fixed field widths of the command and result words.
    localparam int DATA_W      = 32;
    localparam int POS_W       = 16;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    // Default number of list slots.
    localparam int CAPACITY_DEF = 16;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_GET      = 3'd0,
        FUNC_ADD_HEAD = 3'd1,
        FUNC_ADD_TAIL = 3'd2,
        FUNC_ADD_AT   = 3'd3,
        FUNC_DELETE   = 3'd4
    } t_func;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Command broadcast to the cell chain in the cycle a word is accepted.
    typedef struct packed {
        logic ins;  // open a slot at the target and load the new value
        logic del;  // close the slot at the target
    } t_cell_cmd;

endpackage

// ===== src/ilid_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilid_cell: one slot of the list
// Holds one value and, on an insert or delete command, takes its value from
// the new word or from the neighbour on either side.
// ----------------------------------------------------------------------------
module ilid_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 4
) (
    input  logic                        i_clk,
    input  ilid_pkg::t_cell_cmd         i_cmd,
    input  logic [IDX_W-1:0]            i_at,
    input  logic [ilid_pkg::DATA_W-1:0] i_new_value,
    input  logic [ilid_pkg::DATA_W-1:0] i_left_value,
    input  logic [ilid_pkg::DATA_W-1:0] i_right_value,
    output logic [ilid_pkg::DATA_W-1:0] o_value,
    output logic [ilid_pkg::DATA_W-1:0] o_tap
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

    logic [ilid_pkg::DATA_W-1:0] r_value;
    logic                        above_at;
    logic                        at_here;

    // Position of this slot relative to the target slot.
    assign above_at = (MY_INDEX > i_at);
    assign at_here  = (MY_INDEX == i_at);

    // Insert shifts slots above the target up by one; delete shifts the
    // target and everything above it down by one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (above_at) begin
                r_value <= i_left_value;
            end else if (at_here) begin
                r_value <= i_new_value;
            end
        end else if (i_cmd.del) begin
            if (above_at || at_here) begin
                r_value <= i_right_value;
            end
        end
    end

    assign o_value = r_value;

    // Read tap: only the addressed slot drives a non-zero value.
    assign o_tap = at_here ? r_value : '0;

endmodule

// ===== src/indexed_list_insert_delete_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core: ordered list with indexed insert/delete
// Keeps up to CAPACITY signed values in a row of cells and a count; each
// command word gets, inserts or deletes, and returns one result word.
// ----------------------------------------------------------------------------
//  Channel   Handshake                    Payload
//  command   start in, busy out           i_func, i_position, i_item_value
//  result    o_valid strobe, one cycle    o_read_value, o_status, o_count_now
//
//  A command word is accepted on any edge with start high; busy stays low, so
//  one word can be taken every cycle. All cells shift together in that cycle.
//  The result word is registered and appears in the cycle after acceptance, for one cycle only.
//  Reset (synchronous, active low) empties the list; cell contents are not
//  cleared, as slots at or above the count are never read.
//  The receiver cannot stall; results are not held back.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_core #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ilid_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [ilid_pkg::POS_W-1:0]  i_position,
    input  logic signed [ilid_pkg::DATA_W-1:0] i_item_value,
    output logic                               o_valid,
    output logic signed [ilid_pkg::DATA_W-1:0] o_read_value,
    output logic [ilid_pkg::STATUS_W-1:0]      o_status,
    output logic [ilid_pkg::COUNT_OUT_W-1:0]   o_count_now
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = 32;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    // Registers.
    logic [CNT_W-1:0]                  r_count;
    logic                              r_valid;
    logic [ilid_pkg::DATA_W-1:0]       r_read_value;
    ilid_pkg::t_status                 r_status;
    logic [ilid_pkg::COUNT_OUT_W-1:0]  r_count_now;

    // Next values.
    logic [CNT_W-1:0]                  n_count;
    logic [ilid_pkg::DATA_W-1:0]       n_read_value;
    ilid_pkg::t_status                 n_status;

    // Decode signals.
    ilid_pkg::t_cell_cmd               cmd;
    logic [IDX_W-1:0]                  at;
    logic [CMP_W-1:0]                  pos_mag;
    logic [CMP_W-1:0]                  cnt_ext;
    logic                              pos_neg;
    logic                              pos_zero;
    logic                              pos_in_list;
    logic                              pos_above_cnt;
    logic                              full;
    logic [ilid_pkg::DATA_W-1:0]       get_value;
    logic [CNT_W+ilid_pkg::COUNT_OUT_W-1:0] cnt_wide;

    // Cell chain wiring.
    logic [ilid_pkg::DATA_W-1:0]       cell_value [CAPACITY];
    logic [ilid_pkg::DATA_W-1:0]       cell_tap   [CAPACITY];

    // Range checks on the signed position against the current count.
    assign pos_neg       = i_position[ilid_pkg::POS_W-1];
    assign pos_mag       = CMP_W'(i_position[ilid_pkg::POS_W-2:0]);
    assign cnt_ext       = CMP_W'(r_count);
    assign pos_zero      = (pos_mag == '0);
    assign pos_in_list   = !pos_neg && (pos_mag < cnt_ext);
    assign pos_above_cnt = !pos_neg && (pos_mag > cnt_ext);
    assign full          = (r_count >= CNT_FULL);

    // Gather the addressed slot from the read taps.
    always_comb begin
        get_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            get_value = get_value | cell_tap[k];
        end
    end

    // Operation decode: target slot, cell command, status and new count.
    always_comb begin
        cmd          = '0;
        at           = i_position[IDX_W-1:0];
        n_count      = r_count;
        n_read_value = '0;
        n_status     = ilid_pkg::ST_DONE;
        case (ilid_pkg::t_func'(i_func))
            ilid_pkg::FUNC_GET: begin
                if (pos_in_list) begin
                    n_read_value = get_value;
                end else begin
                    n_read_value = '1;
                    n_status     = ilid_pkg::ST_INVALID;
                end
            end
            ilid_pkg::FUNC_ADD_HEAD: begin
                at = '0;
                if (full) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ilid_pkg::FUNC_ADD_TAIL: begin
                at = r_count[IDX_W-1:0];
                if (full) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ilid_pkg::FUNC_ADD_AT: begin
                if (pos_neg || pos_zero) begin
                    at = '0;
                end
                if (pos_above_cnt) begin
                    n_status = ilid_pkg::ST_INVALID;
                end else if (full) begin
                    n_status = ilid_pkg::ST_FULL;
                end else begin
                    cmd.ins = 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            ilid_pkg::FUNC_DELETE: begin
                if (pos_in_list) begin
                    cmd.del = 1'b1;
                    n_count = r_count - 1'b1;
                end else begin
                    n_status = ilid_pkg::ST_INVALID;
                end
            end
            default: begin
                n_status = ilid_pkg::ST_INVALID;
            end
        endcase
        // Only accepted words act on the list.
        if (!start) begin
            cmd     = '0;
            n_count = r_count;
        end
    end

    // Row of storage cells; each sees its two neighbours.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ilid_pkg::DATA_W-1:0] left_value;
        logic [ilid_pkg::DATA_W-1:0] right_value;

        if (k == 0) begin : g_first
            assign left_value = i_item_value;
        end else begin : g_left
            assign left_value = cell_value[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_value = cell_value[k];
        end else begin : g_right
            assign right_value = cell_value[k+1];
        end

        ilid_cell #(
            .INDEX (k),
            .IDX_W (IDX_W)
        ) u_cell (
            .i_clk         (i_clk),
            .i_cmd         (cmd),
            .i_at          (at),
            .i_new_value   (i_item_value),
            .i_left_value  (left_value),
            .i_right_value (right_value),
            .o_value       (cell_value[k]),
            .o_tap         (cell_tap[k])
        );
    end

    // Count and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= start;
        end
    end

    // Low bits of the new count for the result word.
    assign cnt_wide = {{ilid_pkg::COUNT_OUT_W{1'b0}}, n_count};

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_read_value <= n_read_value;
            r_status     <= n_status;
            r_count_now  <= cnt_wide[ilid_pkg::COUNT_OUT_W-1:0];
        end
    end

    assign busy         = 1'b0;
    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count_now  = r_count_now;

endmodule

// ===== sim/tb_indexed_list_insert_delete_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_list_insert_delete_core: self-checking bench for the list core
// Command words go in through start/busy from a queue filled up front. A
// shadow copy of the list predicts every result word. A monitor compares each
// strobed result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_indexed_list_insert_delete_core;
    import ilid_pkg::*;

    localparam int SLOTS          = CAPACITY_DEF;
    localparam int RANDOM_WORDS   = 1100;
    localparam int CALM_FROM      = 900;   // no idling from this word onwards
    localparam int SEGMENT_WORDS  = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 5;

    // Operation codes that the core does not implement.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_7 = 3'd7;

    // Random stimulus moods.
    localparam int MOOD_FILL  = 0;
    localparam int MOOD_DRAIN = 1;
    localparam int MOOD_MIXED = 2;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic signed [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] item_value;
        int                       gap;   // idle cycles before the word is offered
        bit                       hold;  // offer only once every result has come
    } list_op_t;

    typedef struct {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_OUT_W-1:0]   count_now;
    } list_result_t;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic [FUNC_W-1:0]           i_func;
    logic signed [POS_W-1:0]     i_position;
    logic signed [DATA_W-1:0]    i_item_value;
    logic                        o_valid;
    logic signed [DATA_W-1:0]    o_read_value;
    logic [STATUS_W-1:0]         o_status;
    logic [COUNT_OUT_W-1:0]      o_count_now;

    list_op_t                 op_words[$];
    list_result_t             awaited_results[$];
    logic signed [DATA_W-1:0] shadow_list[$];
    list_op_t                 drv_head;
    logic                     drv_go;
    list_result_t             mon_want;
    int                       quiet_cycles;
    bit                       failed;

    indexed_list_insert_delete_core #(
        .CAPACITY(SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_status     (o_status),
        .o_count_now  (o_count_now)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = ~i_clk;
    end

    // Appends one command word to the queue of words waiting to be driven.
    function automatic void queue_op(input logic [FUNC_W-1:0] f, input int p,
                                     input logic [DATA_W-1:0] v, input int gap,
                                     input bit hold);
        list_op_t w;
        w.func       = f;
        w.position   = p[POS_W-1:0];
        w.item_value = v;
        w.gap        = gap;
        w.hold       = hold;
        op_words.push_back(w);
    endfunction

    // Inserts into the shadow list unless it is already full.
    function automatic logic [STATUS_W-1:0] place_value(input int at,
                                                        input logic [DATA_W-1:0] v);
        if (shadow_list.size() >= SLOTS) begin
            return ST_FULL;
        end
        shadow_list.insert(at, v);
        return ST_DONE;
    endfunction

    // Applies one accepted word to the shadow list and records the result
    // word that the core should return for it.
    function automatic void apply_list_op(input list_op_t w);
        list_result_t r;
        int           pos;
        int           cnt;
        r.read_value = '0;
        r.status     = ST_DONE;
        pos          = w.position;
        cnt          = shadow_list.size();
        case (w.func)
            FUNC_GET: begin
                if (pos >= 0 && pos < cnt) begin
                    r.read_value = shadow_list[pos];
                end else begin
                    r.read_value = '1;
                    r.status     = ST_INVALID;
                end
            end
            FUNC_ADD_HEAD: begin
                r.status = place_value(0, w.item_value);
            end
            FUNC_ADD_TAIL: begin
                r.status = place_value(cnt, w.item_value);
            end
            FUNC_ADD_AT: begin
                // A position past the end is rejected before fullness is looked at.
                if (pos <= 0) begin
                    r.status = place_value(0, w.item_value);
                end else if (pos > cnt) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = place_value(pos, w.item_value);
                end
            end
            FUNC_DELETE: begin
                if (pos >= 0 && pos < cnt) begin
                    shadow_list.delete(pos);
                end else begin
                    r.status = ST_INVALID;
                end
            end
            default: begin
                r.status = ST_INVALID;
            end
        endcase
        r.count_now = COUNT_OUT_W'(shadow_list.size());
        awaited_results.push_back(r);
    endfunction

    // Driver: predicts each word as it is accepted, then offers the next one
    // after its idle gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_list_op(op_words.pop_front());
            end
            drv_go = 1'b0;
            if (start && busy) begin
                // The word has not been taken yet, so it stays on the ports.
                drv_go = 1'b1;
            end else if (op_words.size() != 0) begin
                drv_head = op_words[0];
                if (drv_head.gap > 0) begin
                    drv_head.gap = drv_head.gap - 1;
                    op_words[0]  = drv_head;
                end else if (!drv_head.hold || awaited_results.size() == 0) begin
                    drv_go = 1'b1;
                end
            end
            start <= drv_go;
            if (drv_go) begin
                i_func       <= op_words[0].func;
                i_position   <= op_words[0].position;
                i_item_value <= op_words[0].item_value;
            end
        end
    end

    // Monitor: every strobed result word is matched against the oldest
    // prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                $error("result word with nothing expected: read_value %0d, status %0d, count %0d",
                       o_read_value, o_status, o_count_now);
                failed = 1'b1;
            end else begin
                mon_want = awaited_results.pop_front();
                if (o_read_value !== mon_want.read_value) begin
                    $error("read_value: expected %0d, got %0d", mon_want.read_value, o_read_value);
                    failed = 1'b1;
                end
                if (o_status !== mon_want.status) begin
                    $error("status: expected %0d, got %0d", mon_want.status, o_status);
                    failed = 1'b1;
                end
                if (o_count_now !== mon_want.count_now) begin
                    $error("count_now: expected %0d, got %0d", mon_want.count_now, o_count_now);
                    failed = 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_indexed_list_insert_delete_core: FAIL");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int               n;
        int               mood;
        bit               idling;
        int               roll;
        int               pos;
        logic [DATA_W-1:0] val;
        logic [FUNC_W-1:0] f;
        int               gap;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_func       = FUNC_GET;
        i_position   = '0;
        i_item_value = '0;
        failed       = 1'b0;
        quiet_cycles = 0;

        // Directed words: the empty list, both ends of each field, index
        // inserts at, below and beyond the end, and the unused codes.
        queue_op(FUNC_GET,      0,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_DELETE,   0,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_ADD_HEAD, 0,      32'h7FFF_FFFF, 0, 1'b0);
        queue_op(FUNC_ADD_TAIL, 0,      32'h8000_0000, 2, 1'b0);
        queue_op(FUNC_ADD_AT,   -32768, 32'hFFFF_FFFF, 0, 1'b0);
        queue_op(FUNC_ADD_AT,   3,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_ADD_AT,   5,      32'h1234_5678, 0, 1'b0);
        queue_op(FUNC_ADD_AT,   32767,  32'h1234_5678, 0, 1'b0);
        queue_op(FUNC_ADD_AT,   2,      32'h5555_5555, 1, 1'b0);
        queue_op(FUNC_ADD_AT,   1,      32'hAAAA_AAAA, 0, 1'b0);
        queue_op(FUNC_GET,      0,      32'hFFFF_FFFF, 0, 1'b0);
        queue_op(FUNC_GET,      5,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_GET,      6,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_GET,      -1,     32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_GET,      32767,  32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_DELETE,   2,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_DELETE,   -32768, 32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_DELETE,   5,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_DELETE,   4,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_UNUSED_5, 1,      32'hFFFF_FFFF, 0, 1'b0);
        queue_op(FUNC_UNUSED_6, 0,      32'h0000_0000, 0, 1'b0);
        queue_op(FUNC_UNUSED_7, -1,     32'h7FFF_FFFF, 0, 1'b0);

        // Random words in segments that fill, drain or churn the list, so
        // that both the full and the empty list come up again and again.
        for (n = 0; n < RANDOM_WORDS; n = n + 1) begin
            if (n % SEGMENT_WORDS == 0) begin
                mood   = (n == 0) ? MOOD_FILL : $urandom_range(MOOD_FILL, MOOD_MIXED);
                idling = (n < CALM_FROM) && ($urandom_range(0, 3) != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll >= 95) begin
                f = FUNC_UNUSED_5 + FUNC_W'($urandom_range(0, 2));
            end else if ((mood == MOOD_FILL && roll < 70) ||
                         (mood == MOOD_DRAIN && roll >= 80) ||
                         (mood == MOOD_MIXED && roll < 45)) begin
                case ($urandom_range(0, 2))
                    0:       f = FUNC_ADD_HEAD;
                    1:       f = FUNC_ADD_TAIL;
                    default: f = FUNC_ADD_AT;
                endcase
            end else if ((mood == MOOD_FILL && roll < 85) ||
                         (mood == MOOD_DRAIN && roll < 20) ||
                         (mood == MOOD_MIXED && roll < 70)) begin
                f = FUNC_GET;
            end else begin
                f = FUNC_DELETE;
            end

            // Mostly positions around the live range, now and then any value.
            if ($urandom_range(0, 9) == 0) begin
                pos = int'($urandom_range(0, 65535)) - 32768;
            end else begin
                pos = int'($urandom_range(0, SLOTS + 3)) - 2;
            end
            if ($urandom_range(0, 9) == 0) begin
                val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end else begin
                val = $urandom;
            end
            gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 15) : 0;
            // The first random word, and a few others before the calm part,
            // wait for a drained core.
            queue_op(f, pos, val, gap,
                     (n == 0) || ((n < CALM_FROM) && ($urandom_range(0, 199) == 0)));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_words.size() != 0 || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (!failed && awaited_results.size() == 0) begin
            $display("tb_indexed_list_insert_delete_core: PASS");
        end else begin
            $display("tb_indexed_list_insert_delete_core: FAIL");
        end
        $finish;
    end

endmodule

// ===== indexed_list_insert_delete_core.f =====
src/ilid_pkg.sv
src/ilid_cell.sv
src/indexed_list_insert_delete_core.sv
sim/tb_indexed_list_insert_delete_core.sv
